// File: rtl/bfpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfpd_pkg;

  // Store geometry and packet bounds
  localparam int FIFO_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(FIFO_DEPTH);
  localparam int PACKET_MAX = 64;
  localparam int LIMIT_W    = 7;

  // Operation codes
  localparam logic OP_PUT     = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       link_configured;
    logic       link_ready;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_packet;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/byte_fifo_packet_drain.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte FIFO (1023 usable bytes) that drains into packets. A put word is
// dropped silently when the FIFO is full. A service word with the link down
// flushes the FIFO; with the link up and ready and bytes waiting it holds busy
// while it drains N bytes, N = min(fill level, packet_limit), one
// store read per cycle on the single read port. Each drained byte shows on
// result for exactly one cycle with strobe, in the cycle after its read, the last
// byte of the packet marked last_of_packet. There is no way to stall results:
// the receiver must take every strobed word. packet_limit of 0 acts as 1,
// above 64 acts as 64; write it only while the block is idle.
module byte_fifo_packet_drain
  import bfpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire item_t              item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data,
  output logic                    strobe,
  output result_t                 result
);

  logic [7:0]          mem [FIFO_DEPTH];
  logic [7:0]          mem_q;
  logic [ADDR_W-1:0]   rd_ptr;
  logic [ADDR_W-1:0]   wr_ptr;
  logic [LIMIT_W-1:0]  packet_limit;
  logic [LIMIT_W-1:0]  cnt;
  logic                rd_vld;
  logic                rd_last;
  state_t              state;
  state_t              state_next;

  logic                accept;
  logic [ADDR_W-1:0]   level;
  logic                full;
  logic [LIMIT_W-1:0]  lim;
  logic [LIMIT_W-1:0]  count;
  logic                do_put;
  logic                do_flush;
  logic                do_drain;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Fill level wraps with the pointers
  assign level = wr_ptr - rd_ptr;
  assign full  = (level == ADDR_W'(FIFO_DEPTH - 1));

  // Clamp the packet limit into 1..PACKET_MAX
  always_comb begin
    if (packet_limit == '0) begin
      lim = LIMIT_W'(1);
    end else if (packet_limit > LIMIT_W'(PACKET_MAX)) begin
      lim = LIMIT_W'(PACKET_MAX);
    end else begin
      lim = packet_limit;
    end
    count = (level < ADDR_W'(lim)) ? level[LIMIT_W-1:0] : lim;
  end

  assign do_put   = accept && (item.operation == OP_PUT) && !full;
  assign do_flush = accept && (item.operation == OP_SERVICE) && !item.link_configured;
  assign do_drain = accept && (item.operation == OP_SERVICE) && item.link_configured &&
                    item.link_ready && (level != '0);

  // Next state and busy
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (do_drain) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        busy = 1'b1;
        if (cnt == LIMIT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Store: one write port for puts, one registered read port for draining
  always_ff @(posedge clk) begin
    if (do_put) begin
      mem[wr_ptr] <= item.data_byte;
    end
    mem_q <= mem[rd_ptr];
  end

  // Pointers, drain counter and read-return tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      packet_limit <= LIMIT_W'(PACKET_MAX);
      cnt          <= '0;
      rd_vld       <= 1'b0;
      rd_last      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        packet_limit <= cfg_data;
      end
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
      if (do_put) begin
        wr_ptr <= wr_ptr + ADDR_W'(1);
      end
      if (do_flush) begin
        rd_ptr <= '0;
        wr_ptr <= '0;
      end
      if (do_drain) begin
        cnt <= count;
      end
      if (state == ST_DRAIN) begin
        rd_ptr  <= rd_ptr + ADDR_W'(1);
        cnt     <= cnt - LIMIT_W'(1);
        rd_vld  <= 1'b1;
        rd_last <= (cnt == LIMIT_W'(1));
      end
    end
  end

  assign strobe                = rd_vld;
  assign result.out_byte       = mem_q;
  assign result.last_of_packet = rd_last;

  // Checks
  a_strobe_after_drain: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_DRAIN))
    else $error("result word without a read in flight");

  a_drain_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (level != '0))
    else $error("drain read from an empty FIFO");

  a_last_ends_packet: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_of_packet) |=> !strobe)
    else $error("word follows the last word of a packet");

  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.operation == OP_PUT) && full) |=> $stable(wr_ptr))
    else $error("write pointer moved on a put to a full FIFO");

endmodule
`default_nettype wire

// File: verif/drain_checker.sv
`timescale 1ns / 1ps
// Shadow FIFO for the packet drain: tracks puts, flushes and config writes,
// queues the bytes each service word must drain, and checks every strobed word.
module drain_checker
  import bfpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  item_t              item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               strobe,
  input  result_t            result,
  output int                 errors,
  output int                 outstanding,
  output int                 bytes_checked,
  output int                 puts_dropped,
  output int                 flushes
);

  logic [7:0]         shadow_store [FIFO_DEPTH];
  logic [ADDR_W-1:0]  rd_ptr;
  logic [ADDR_W-1:0]  wr_ptr;
  logic [LIMIT_W-1:0] pkt_limit;
  result_t            drain_queue [$];
  int                 err_cnt   = 0;
  int                 chk_cnt   = 0;
  int                 drop_cnt  = 0;
  int                 flush_cnt = 0;

  assign errors        = err_cnt;
  assign bytes_checked = chk_cnt;
  assign puts_dropped  = drop_cnt;
  assign flushes       = flush_cnt;

  // Apply one accepted command word to the shadow FIFO
  task automatic predict_word(input item_t w);
    logic [ADDR_W-1:0] fill;
    int unsigned       cap;
    int unsigned       count;
    result_t           r;
    fill = wr_ptr - rd_ptr;
    if (w.operation == OP_PUT) begin
      // one slot always stays empty, so 1023 bytes means full
      if (fill != ADDR_W'(FIFO_DEPTH - 1)) begin
        shadow_store[wr_ptr] = w.data_byte;
        wr_ptr = wr_ptr + ADDR_W'(1);
      end else begin
        drop_cnt++;
      end
    end else if (!w.link_configured) begin
      // link down: pointers back to zero, contents kept
      rd_ptr = '0;
      wr_ptr = '0;
      flush_cnt++;
    end else if (w.link_ready && fill != '0) begin
      cap = 32'(pkt_limit);
      if (cap == 0) cap = 1;
      if (cap > PACKET_MAX) cap = PACKET_MAX;
      count = (32'(fill) < cap) ? 32'(fill) : cap;
      for (int unsigned k = 0; k < count; k++) begin
        r.out_byte       = shadow_store[rd_ptr];
        r.last_of_packet = (k + 1 == count);
        drain_queue.push_back(r);
        rd_ptr = rd_ptr + ADDR_W'(1);
      end
    end
  endtask

  // Results first: a word strobed now always belongs to an earlier command
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rd_ptr    = '0;
      wr_ptr    = '0;
      pkt_limit = LIMIT_W'(PACKET_MAX);
      drain_queue.delete();
    end else begin
      if (strobe) begin
        if (drain_queue.size() == 0) begin
          err_cnt++;
          $display("%0t chk: unexpected word, expected none, got byte %02h last %0b",
                   $time, result.out_byte, result.last_of_packet);
        end else begin
          want = drain_queue.pop_front();
          chk_cnt++;
          if (result.out_byte !== want.out_byte) begin
            err_cnt++;
            $display("%0t chk: out_byte expected %02h, got %02h",
                     $time, want.out_byte, result.out_byte);
          end
          if (result.last_of_packet !== want.last_of_packet) begin
            err_cnt++;
            $display("%0t chk: last_of_packet expected %0b, got %0b",
                     $time, want.last_of_packet, result.last_of_packet);
          end
        end
      end
      if (cfg_valid && cfg_ready) pkt_limit = cfg_data;
      if (start && !busy) predict_word(item);
    end
    outstanding <= drain_queue.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import bfpd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int FILL_WORDS    = FIFO_DEPTH + 6;
  localparam int PHASE_WORDS   = 44;
  localparam int PLAN_LEN      = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_PLAN [PLAN_LEN] = '{64, 2, 1, 0, 127, 5, 33};

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  item_t              item      = '0;
  logic               cfg_valid = 1'b0;
  logic [LIMIT_W-1:0] cfg_data  = '0;
  logic               busy;
  logic               cfg_ready;
  logic               strobe;
  result_t            result;
  int                 errors;
  int                 outstanding;
  int                 bytes_checked;
  int                 puts_dropped;
  int                 flushes;
  int                 words_sent   = 0;
  int                 stall_cycles = 0;

  always #4 clk = ~clk;

  byte_fifo_packet_drain dut (
    .clk, .rst, .start, .busy, .item,
    .cfg_valid, .cfg_ready, .cfg_data,
    .strobe, .result
  );

  drain_checker chk (
    .clk, .rst, .start, .busy, .item,
    .cfg_valid, .cfg_ready, .cfg_data,
    .strobe, .result,
    .errors, .outstanding, .bytes_checked, .puts_dropped, .flushes
  );

  // Watchdog: cycles with no command, config or result word accepted
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Put word; the link fields are don't-care here
  function automatic item_t put_word(input logic [7:0] b);
    item_t w;
    w.operation       = OP_PUT;
    w.data_byte       = b;
    w.link_configured = 1'($urandom_range(0, 1));
    w.link_ready      = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Service word; data_byte is don't-care here
  function automatic item_t service_word(input logic up, input logic rdy);
    item_t w;
    w.operation       = OP_SERVICE;
    w.data_byte       = 8'($urandom_range(0, 255));
    w.link_configured = up;
    w.link_ready      = rdy;
    return w;
  endfunction

  // Mostly puts with drains on a live link, a few flushes and not-ready ticks
  function automatic item_t random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return put_word(8'($urandom_range(0, 255)));
    return service_word($urandom_range(0, 99) >= 8, $urandom_range(0, 99) < 80);
  endfunction

  function automatic int gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the word until the block takes it; start stays high on return
  task automatic send(input item_t w);
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      item  <= random_word();
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait for every queued byte, then let the block go idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                 p;
    int                 k;
    logic [LIMIT_W-1:0] lim;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset limit: empty drain, byte extremes, not ready, flush
    send(service_word(1'b1, 1'b1));
    send(put_word(8'h00));
    send(put_word(8'hFF));
    send(put_word(8'hA5));
    send(put_word(8'h5A));
    send(service_word(1'b1, 1'b0));
    send(service_word(1'b1, 1'b1));
    send(put_word(8'h11));
    send(put_word(8'h22));
    send(service_word(1'b0, 1'b1));
    send(service_word(1'b1, 1'b1));
    send(put_word(8'h33));
    pause(2);
    send(service_word(1'b1, 1'b1));

    // One-byte packets
    set_limit(7'd1);
    send(put_word(8'h44));
    send(put_word(8'h55));
    send(put_word(8'h66));
    send(service_word(1'b1, 1'b1));
    send(service_word(1'b1, 1'b1));
    send(service_word(1'b0, 1'b0));

    // Zero limit behaves as one
    set_limit(7'd0);
    send(put_word(8'h77));
    send(put_word(8'h88));
    send(service_word(1'b1, 1'b1));
    send(service_word(1'b0, 1'b1));

    // Oversized limit saturates; overfill, then drain dry so pointers sit at the top
    set_limit(7'd127);
    repeat (FILL_WORDS) send(put_word(8'($urandom_range(0, 255))));
    repeat (17) send(service_word(1'b1, 1'b1));

    // Random phases, one packet limit each; phase 4 streams with no gaps
    for (p = 0; p <= PLAN_LEN; p++) begin
      lim = (p < PLAN_LEN) ? LIMIT_PLAN[p] : LIMIT_W'($urandom_range(1, PACKET_MAX));
      set_limit(lim);
      for (k = 0; k < PHASE_WORDS; k++) begin
        send(random_word());
        if (p != 4) pause(gap_len());
      end
    end

    settle();
    $display("tb: %0d command words, %0d drained bytes checked, %0d puts dropped, %0d flushes",
             words_sent, bytes_checked, puts_dropped, flushes);
    $display("tb: limits 0, 1, 2, 5, 33, 64, 127 and a random one; overfill and pointer wrap");
    if (errors == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
